// ----- hdl/csl_pkg.sv -----
// Types, constants and per-character lexer functions for comment_strip_lexer.
// No dependencies; used by the top, core, result bank and both bench files.
`default_nettype none
package csl_pkg;

	localparam int TEXT_BYTES    = 8;
	localparam int MAX_TOKEN_LEN = 255;
	localparam int TB_W          = 8 * TEXT_BYTES;
	localparam int CNT_W         = $clog2(MAX_TOKEN_LEN + 2);
	localparam int RES_MAX       = 3;
	localparam int RES_IDX_W     = 2;

	localparam logic [1:0] KIND_TOKEN = 2'd0;
	localparam logic [1:0] KIND_ERROR = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_BAD_CHAR  = 3'd1;
	localparam logic [2:0] ERR_EDGE_DOT  = 3'd2;
	localparam logic [2:0] ERR_LEAD_ZERO = 3'd3;
	localparam logic [2:0] ERR_EXTRA_DOT = 3'd4;

	localparam logic [4:0] CLS_AO     = 5'd8;
	localparam logic [4:0] CLS_RO     = 5'd9;
	localparam logic [4:0] CLS_LO     = 5'd10;
	localparam logic [4:0] CLS_PLUS   = 5'd11;
	localparam logic [4:0] CLS_MINUS  = 5'd12;
	localparam logic [4:0] CLS_TIMES  = 5'd13;
	localparam logic [4:0] CLS_DIV    = 5'd14;
	localparam logic [4:0] CLS_COMMA  = 5'd15;
	localparam logic [4:0] CLS_BRACE  = 5'd16;
	localparam logic [4:0] CLS_SEMI   = 5'd17;
	localparam logic [4:0] CLS_IDENT  = 5'd18;
	localparam logic [4:0] CLS_INT    = 5'd19;
	localparam logic [4:0] CLS_DOUBLE = 5'd20;
	localparam logic [4:0] CLS_UNCLS  = 5'd21;

	// keyword text, first char in low byte; index is the class code
	localparam logic [63:0] KW_TEXT [8] = '{
		64'h0000_0000_0074_6e69, 64'h0000_656c_6275_6f64,
		64'h0000_0066_6e61_6373, 64'h0000_6674_6e69_7270,
		64'h0000_0000_0000_6669, 64'h0000_0000_6e65_6874,
		64'h0000_0065_6c69_6877, 64'h0000_0000_0000_6f64
	};
	localparam int KW_LEN [8] = '{3, 6, 5, 6, 2, 4, 5, 2};

	typedef enum logic [1:0] {CM_NORMAL, CM_BLOCK, CM_LINE} cm_t;
	typedef enum logic [2:0] {LX_IDLE, LX_WORD, LX_NUM, LX_OPEQ, LX_OPREP, LX_DONE} lx_t;

	typedef struct packed {
		cm_t               cmode;
		logic              held;
		logic              star;
		logic              last_sp;
		lx_t               lx;
		logic [TB_W-1:0]   tb;
		logic [CNT_W-1:0]  cnt;
		logic [1:0]        dots;
		logic [7:0]        last_b;
		logic [7:0]        sec_b;
		logic              halted;
	} lst_t;

	localparam lst_t LST_RESET = '0;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  cls;
		logic [7:0]  len;
		logic [63:0] text;
		logic        trunc;
		logic [2:0]  err;
		logic        last;
	} res_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic res_t mk_err(input logic [2:0] code);
		res_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.err = code;
		return r;
	endfunction

	function automatic void finish_token(inout lst_t s, output res_t r, output logic v);
		logic [4:0] cls;
		logic [7:0] first;
		logic       two;
		logic [2:0] err;
		r = '0;
		v = 1'b0;
		cls = CLS_IDENT;
		err = ERR_NONE;
		first = s.tb[7:0];
		two = s.cnt >= CNT_W'(2);
		case (s.lx)
			LX_IDLE: ;
			LX_WORD: begin
				for (int i = 7; i >= 0; i--)
					if (s.cnt == CNT_W'(KW_LEN[i]) && 64'(s.tb) == KW_TEXT[i])
						cls = 5'(i);
			end
			LX_NUM: begin
				if (first == "." || s.last_b == ".")
					err = ERR_EDGE_DOT;
				else if (first == "0" && s.cnt > CNT_W'(1) && s.sec_b != ".")
					err = ERR_LEAD_ZERO;
				else if (s.dots >= 2'd2)
					err = ERR_EXTRA_DOT;
				cls = (s.dots != 2'd0) ? CLS_DOUBLE : CLS_INT;
			end
			default: begin
				case (first)
					"=": cls = two ? CLS_RO : CLS_AO;
					">", "<": cls = CLS_RO;
					"!": cls = two ? CLS_RO : CLS_LO;
					"&", "|": cls = two ? CLS_LO : CLS_UNCLS;
					"+": cls = CLS_PLUS;
					"-": cls = CLS_MINUS;
					"*": cls = CLS_TIMES;
					"/": cls = CLS_DIV;
					",": cls = CLS_COMMA;
					";": cls = CLS_SEMI;
					default: cls = CLS_BRACE;
				endcase
			end
		endcase
		if (s.lx != LX_IDLE) begin
			v = 1'b1;
			if (err != ERR_NONE) begin
				r = mk_err(err);
				s.halted = 1'b1;
			end else begin
				r.kind = KIND_TOKEN;
				r.cls = cls;
				r.len = (s.cnt > CNT_W'(MAX_TOKEN_LEN)) ? 8'(MAX_TOKEN_LEN) : 8'(s.cnt);
				r.text = 64'(s.tb);
				r.trunc = s.cnt > CNT_W'(TEXT_BYTES);
				s.lx = LX_IDLE;
			end
		end
	endfunction

	function automatic void add_byte(inout lst_t s, input logic [7:0] c);
		for (int i = 0; i < TEXT_BYTES; i++)
			if (s.cnt == CNT_W'(i))
				s.tb[8*i +: 8] = c;
		if (s.cnt == CNT_W'(1))
			s.sec_b = c;
		s.last_b = c;
		if (c == "." && s.dots < 2'd2)
			s.dots = s.dots + 2'd1;
		if (s.cnt <= CNT_W'(MAX_TOKEN_LEN))
			s.cnt = s.cnt + CNT_W'(1);
	endfunction

	function automatic void start_token(inout lst_t s, input logic [7:0] c, input lx_t st);
		s.tb = '0;
		s.tb[7:0] = c;
		s.cnt = CNT_W'(1);
		s.dots = (c == ".") ? 2'd1 : 2'd0;
		s.last_b = c;
		s.sec_b = 8'd0;
		s.lx = st;
	endfunction

	function automatic void lex_char(inout lst_t s, input logic [7:0] c,
			output res_t r0, output logic v0, output res_t r1, output logic v1);
		logic take;
		take = 1'b0;
		r0 = '0;
		r1 = '0;
		v0 = 1'b0;
		v1 = 1'b0;
		case (s.lx)
			LX_WORD:  take = is_letter(c) || is_digit(c);
			LX_NUM:   take = is_digit(c) || c == ".";
			LX_OPEQ:  take = c == "=";
			LX_OPREP: take = c == s.tb[7:0];
			default:  take = 1'b0;
		endcase
		if (take) begin
			add_byte(s, c);
			if (s.lx == LX_OPEQ || s.lx == LX_OPREP)
				s.lx = LX_DONE;
		end else begin
			finish_token(s, r0, v0);
			if (!s.halted && c != " ") begin
				if (is_letter(c))
					start_token(s, c, LX_WORD);
				else if (is_digit(c) || c == ".")
					start_token(s, c, LX_NUM);
				else if (c == "=" || c == ">" || c == "<" || c == "!")
					start_token(s, c, LX_OPEQ);
				else if (c == "&" || c == "|")
					start_token(s, c, LX_OPREP);
				else if (c == "{" || c == "}" || c == ";" || c == "(" || c == ")" ||
						c == "," || c == "+" || c == "-" || c == "*" || c == "/")
					start_token(s, c, LX_DONE);
				else begin
					r1 = mk_err(ERR_BAD_CHAR);
					v1 = 1'b1;
					s.halted = 1'b1;
				end
			end
		end
	endfunction

	function automatic void pass_char(inout lst_t s, input logic [7:0] c,
			output res_t r0, output logic v0, output res_t r1, output logic v1);
		logic [7:0] cc;
		cc = (c == 8'h0a || c == 8'h09 || c == 8'h0d) ? " " : c;
		r0 = '0;
		r1 = '0;
		v0 = 1'b0;
		v1 = 1'b0;
		if (!(cc == " " && s.last_sp)) begin
			s.last_sp = cc == " ";
			lex_char(s, cc, r0, v0, r1, v1);
		end
	endfunction

endpackage
`default_nettype wire

// ----- hdl/csl_in_if.sv -----
// Input channel of comment_strip_lexer: one source byte or end mark per word.
// Stand-alone interface, no dependencies.
`default_nettype none
interface csl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;
	logic       end_of_input;

	modport source (output valid, source_byte, end_of_input, input ready);
	modport sink (input valid, source_byte, end_of_input, output ready);
endinterface
`default_nettype wire

// ----- hdl/csl_out_if.sv -----
// Result channel of comment_strip_lexer: one token, error or end word per handshake.
// Stand-alone interface, no dependencies.
`default_nettype none
interface csl_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [4:0]  token_class;
	logic [7:0]  token_length;
	logic [63:0] token_text;
	logic        text_truncated;
	logic [2:0]  error_code;
	logic        last_of_run;

	modport source (output valid, result_kind, token_class, token_length, token_text,
		text_truncated, error_code, last_of_run, input ready);
	modport sink (input valid, result_kind, token_class, token_length, token_text,
		text_truncated, error_code, last_of_run, output ready);
endinterface
`default_nettype wire

// ----- hdl/comment_strip_lexer.sv -----
// Top level of comment_strip_lexer: input register, lexer core, result bank.
// Depends on csl_pkg, csl_in_if, csl_out_if, csl_core, csl_outbuf.
//
// Takes one byte per cycle unless stalled. A byte lands in an input register,
// and the lexer state is updated from it in one pass that yields zero to three
// result words (tokens, an error, the end word). Those words wait in a result
// bank and leave one per cycle while out.ready holds, so a byte that ends two or
// three things holds the next byte until its last word leaves; bytes that yield
// at most one word flow at one per cycle while out.ready holds. After an error
// no more results appear until reset; bytes are still accepted and dropped.
`default_nettype none
module comment_strip_lexer (
	input wire logic clk,
	input wire logic arst_n,
	csl_in_if.sink   in,
	csl_out_if.source out
);
	import csl_pkg::*;

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 eoi_s1;
	logic                 can_load;
	logic                 proc_fire;
	res_t                 step_res [RES_MAX];
	logic [RES_IDX_W-1:0] step_n;
	logic                 halted;

	assign proc_fire = valid_s1 && can_load;
	assign in.ready = !valid_s1 || proc_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in.valid && in.ready)
			valid_s1 <= 1'b1;
		else if (proc_fire)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			byte_s1 <= in.source_byte;
			eoi_s1 <= in.end_of_input;
		end
	end

	csl_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (proc_fire),
		.byte_in (byte_s1),
		.eoi     (eoi_s1),
		.res     (step_res),
		.res_n   (step_n),
		.halted  (halted)
	);

	csl_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (proc_fire),
		.res_in   (step_res),
		.n_in     (step_n),
		.can_load (can_load),
		.out      (out)
	);

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		proc_fire && halted |-> step_n == '0)
		else $error("results produced while halted");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.ready && !out.last_of_run |=> out.valid)
		else $error("result run broken before last word");

	a_in_captured: assert property (@(posedge clk) disable iff (!arst_n)
		in.valid && in.ready |=> valid_s1)
		else $error("accepted word not held in input register");
endmodule
`default_nettype wire

// ----- hdl/csl_core.sv -----
// Lexer state register and the single-pass next-state / result logic for one byte.
// Depends on csl_pkg.
`default_nettype none
module csl_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         fire,
	input  wire logic [7:0]                   byte_in,
	input  wire logic                         eoi,
	output csl_pkg::res_t                     res [csl_pkg::RES_MAX],
	output logic [csl_pkg::RES_IDX_W-1:0]     res_n,
	output logic                              halted
);
	import csl_pkg::*;

	lst_t state_q;
	lst_t s;
	res_t a, b, e;
	logic va, vb;
	logic go;

	always_comb begin
		s = state_q;
		res_n = '0;
		for (int i = 0; i < RES_MAX; i++)
			res[i] = '0;
		a = '0;
		b = '0;
		va = 1'b0;
		vb = 1'b0;
		go = 1'b1;
		e = '0;
		e.kind = KIND_END;
		if (!s.halted) begin
			if (eoi) begin
				if (s.cmode == CM_NORMAL && s.held) begin
					s.held = 1'b0;
					pass_char(s, "/", a, va, b, vb);
					if (va) begin res[res_n] = a; res_n = res_n + 1'b1; end
					if (vb) begin res[res_n] = b; res_n = res_n + 1'b1; end
				end
				if (!s.halted) begin
					finish_token(s, a, va);
					if (va) begin res[res_n] = a; res_n = res_n + 1'b1; end
				end
				if (!s.halted) begin
					res[res_n] = e;
					res_n = res_n + 1'b1;
					s = LST_RESET;
				end
			end else begin
				case (s.cmode)
					CM_BLOCK: begin
						if (s.star && byte_in == "/") begin
							s.cmode = CM_NORMAL;
							s.star = 1'b0;
						end else
							s.star = byte_in == "*";
					end
					CM_LINE: begin
						if (byte_in == 8'h0a) begin
							s.cmode = CM_NORMAL;
							if (!s.last_sp) begin
								s.last_sp = 1'b1;
								lex_char(s, " ", a, va, b, vb);
								if (va) begin res[res_n] = a; res_n = res_n + 1'b1; end
								if (vb) begin res[res_n] = b; res_n = res_n + 1'b1; end
							end
						end
					end
					default: begin
						if (s.held) begin
							s.held = 1'b0;
							if (byte_in == "*") begin
								s.cmode = CM_BLOCK;
								s.star = 1'b0;
								go = 1'b0;
							end else if (byte_in == "/") begin
								s.cmode = CM_LINE;
								go = 1'b0;
							end else begin
								pass_char(s, "/", a, va, b, vb);
								if (va) begin res[res_n] = a; res_n = res_n + 1'b1; end
								if (vb) begin res[res_n] = b; res_n = res_n + 1'b1; end
								if (s.halted)
									go = 1'b0;
							end
						end
						if (go) begin
							if (byte_in == "/")
								s.held = 1'b1;
							else begin
								pass_char(s, byte_in, a, va, b, vb);
								if (va) begin res[res_n] = a; res_n = res_n + 1'b1; end
								if (vb) begin res[res_n] = b; res_n = res_n + 1'b1; end
							end
						end
					end
				endcase
			end
		end
		if (res_n != '0)
			res[res_n - 1'b1].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= LST_RESET;
		else if (fire)
			state_q <= s;
	end

	assign halted = state_q.halted;
endmodule
`default_nettype wire

// ----- hdl/csl_outbuf.sv -----
// Result register bank: holds the words of one byte and drains them one per handshake.
// Depends on csl_pkg and csl_out_if.
`default_nettype none
module csl_outbuf (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         load,
	input  wire csl_pkg::res_t                res_in [csl_pkg::RES_MAX],
	input  wire logic [csl_pkg::RES_IDX_W-1:0] n_in,
	output logic                              can_load,
	csl_out_if.source                         out
);
	import csl_pkg::*;

	res_t                 buf_q [RES_MAX];
	logic [RES_IDX_W-1:0] cnt_q;
	logic [RES_IDX_W-1:0] rd_q;
	res_t                 cur;

	assign out.valid = rd_q != cnt_q;
	assign can_load = (rd_q == cnt_q) || ((rd_q + 1'b1) == cnt_q && out.ready);
	assign cur = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= '0;
		end else if (load) begin
			cnt_q <= n_in;
			rd_q <= '0;
		end else if (out.valid && out.ready) begin
			rd_q <= rd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			buf_q <= res_in;
	end

	assign out.result_kind = cur.kind;
	assign out.token_class = cur.cls;
	assign out.token_length = cur.len;
	assign out.token_text = cur.text;
	assign out.text_truncated = cur.trunc;
	assign out.error_code = cur.err;
	assign out.last_of_run = cur.last;
endmodule
`default_nettype wire

// ----- bench/tb_scoreboard.sv -----
// Token scoreboard for comment_strip_lexer: a byte-level lexer predictor and a
// queue of expected result words. Depends on csl_pkg.

class lex_scoreboard;
	csl_pkg::cm_t cmode;
	bit           held, star, last_sp, halted;
	csl_pkg::lx_t lx;
	logic [63:0]  tbytes;
	int unsigned  cnt, dots;
	logic [7:0]   last_b, sec_b;
	csl_pkg::res_t pending[$];
	csl_pkg::res_t step_out[$];
	int errors, tokens, ends, bad;

	function void clear();
		cmode = csl_pkg::CM_NORMAL; held = 0; star = 0; last_sp = 0; halted = 0;
		lx = csl_pkg::LX_IDLE; tbytes = '0; cnt = 0; dots = 0; last_b = 0; sec_b = 0;
	endfunction

	function new();
		clear();
		errors = 0; tokens = 0; ends = 0; bad = 0;
	endfunction

	function void emit(logic [1:0] kind, logic [4:0] cls, logic [7:0] len,
			logic [63:0] txt, logic tr, logic [2:0] err);
		csl_pkg::res_t r;
		r = '0;
		r.kind = kind; r.cls = cls; r.len = len; r.text = txt; r.trunc = tr; r.err = err;
		step_out = {step_out, r};
	endfunction

	function bit raise(logic [2:0] code);
		emit(csl_pkg::KIND_ERROR, 0, 0, 0, 0, code);
		halted = 1;
		return 0;
	endfunction

	function bit is_let(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function bit is_dig(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function bit close_token();
		logic [4:0] cls;
		logic [7:0] f;
		string kw[8];
		logic [63:0] p;
		kw = '{"int", "double", "scanf", "printf", "if", "then", "while", "do"};
		f = tbytes[7:0];
		if (lx == csl_pkg::LX_IDLE) return 1;
		if (lx == csl_pkg::LX_WORD) begin
			cls = csl_pkg::CLS_IDENT;
			for (int i = 7; i >= 0; i--) begin
				p = '0;
				for (int j = 0; j < kw[i].len(); j++) p[8*j +: 8] = kw[i][j];
				if (cnt == kw[i].len() && tbytes == p) cls = 5'(i);
			end
		end else if (lx == csl_pkg::LX_NUM) begin
			if (f == "." || last_b == ".") return raise(csl_pkg::ERR_EDGE_DOT);
			if (f == "0" && cnt > 1 && sec_b != ".") return raise(csl_pkg::ERR_LEAD_ZERO);
			if (dots >= 2) return raise(csl_pkg::ERR_EXTRA_DOT);
			cls = dots ? csl_pkg::CLS_DOUBLE : csl_pkg::CLS_INT;
		end else begin
			case (f)
				"=": cls = cnt >= 2 ? csl_pkg::CLS_RO : csl_pkg::CLS_AO;
				">", "<": cls = csl_pkg::CLS_RO;
				"!": cls = cnt >= 2 ? csl_pkg::CLS_RO : csl_pkg::CLS_LO;
				"&", "|": cls = cnt >= 2 ? csl_pkg::CLS_LO : csl_pkg::CLS_UNCLS;
				"+": cls = csl_pkg::CLS_PLUS;
				"-": cls = csl_pkg::CLS_MINUS;
				"*": cls = csl_pkg::CLS_TIMES;
				"/": cls = csl_pkg::CLS_DIV;
				",": cls = csl_pkg::CLS_COMMA;
				";": cls = csl_pkg::CLS_SEMI;
				default: cls = csl_pkg::CLS_BRACE;
			endcase
		end
		emit(csl_pkg::KIND_TOKEN, cls, cnt > 255 ? 8'd255 : 8'(cnt), tbytes,
			cnt > 8, csl_pkg::ERR_NONE);
		lx = csl_pkg::LX_IDLE;
		return 1;
	endfunction

	function void open_token(logic [7:0] c, csl_pkg::lx_t st);
		tbytes = {56'd0, c}; cnt = 1; dots = (c == ".");
		last_b = c; sec_b = 0; lx = st;
	endfunction

	function void append(logic [7:0] c);
		if (cnt < 8) tbytes[8*cnt +: 8] = c;
		if (cnt == 1) sec_b = c;
		last_b = c;
		if (c == "." && dots < 2) dots++;
		if (cnt <= 255) cnt++;
	endfunction

	function bit scan(logic [7:0] c);
		case (lx)
			csl_pkg::LX_WORD: if (is_let(c) || is_dig(c)) begin append(c); return 1; end
			csl_pkg::LX_NUM: if (is_dig(c) || c == ".") begin append(c); return 1; end
			csl_pkg::LX_OPEQ: if (c == "=") begin
				append(c); lx = csl_pkg::LX_DONE; return 1;
			end
			csl_pkg::LX_OPREP: if (c == tbytes[7:0]) begin
				append(c); lx = csl_pkg::LX_DONE; return 1;
			end
			default: ;
		endcase
		if (!close_token()) return 0;
		if (c == " ") return 1;
		if (is_let(c)) open_token(c, csl_pkg::LX_WORD);
		else if (is_dig(c) || c == ".") open_token(c, csl_pkg::LX_NUM);
		else if (c == "=" || c == ">" || c == "<" || c == "!") open_token(c, csl_pkg::LX_OPEQ);
		else if (c == "&" || c == "|") open_token(c, csl_pkg::LX_OPREP);
		else if (c == "{" || c == "}" || c == ";" || c == "(" || c == ")" || c == "," ||
				c == "+" || c == "-" || c == "*" || c == "/")
			open_token(c, csl_pkg::LX_DONE);
		else return raise(csl_pkg::ERR_BAD_CHAR);
		return 1;
	endfunction

	function bit feed_char(logic [7:0] c);
		if (c == 8'h0a || c == 8'h09 || c == 8'h0d) c = " ";
		if (c == " ") begin
			if (last_sp) return 1;
			last_sp = 1;
		end else last_sp = 0;
		return scan(c);
	endfunction

	// note one accepted input word
	function void note_input(logic [7:0] b, logic eoi);
		bit ok;
		if (halted) return;
		step_out.delete();
		if (eoi) begin
			ok = 1;
			if (cmode == csl_pkg::CM_NORMAL && held) begin held = 0; ok = feed_char("/"); end
			if (ok) ok = close_token();
			if (ok) begin emit(csl_pkg::KIND_END, 0, 0, 0, 0, 0); clear(); end
		end else if (cmode == csl_pkg::CM_BLOCK) begin
			if (star && b == "/") begin cmode = csl_pkg::CM_NORMAL; star = 0; end
			else star = (b == "*");
		end else if (cmode == csl_pkg::CM_LINE) begin
			if (b == 8'h0a) begin
				cmode = csl_pkg::CM_NORMAL;
				if (!last_sp) begin last_sp = 1; void'(scan(" ")); end
			end
		end else begin
			ok = 1;
			if (held) begin
				held = 0;
				if (b == "*") begin cmode = csl_pkg::CM_BLOCK; star = 0; ok = 0; end
				else if (b == "/") begin cmode = csl_pkg::CM_LINE; ok = 0; end
				else ok = feed_char("/");
			end
			if (ok) begin
				if (b == "/") held = 1;
				else void'(feed_char(b));
			end
		end
		if (step_out.size() > 0) step_out[step_out.size()-1].last = 1;
		foreach (step_out[i]) pending = {pending, step_out[i]};
	endfunction

	function void check_result(csl_pkg::res_t got);
		csl_pkg::res_t e;
		if (pending.size() == 0) begin
			$error("unexpected result word kind=%0d", got.kind);
			bad++;
			return;
		end
		e = pending.pop_front();
		case (got.kind)
			csl_pkg::KIND_TOKEN: tokens++;
			csl_pkg::KIND_ERROR: errors++;
			default: ends++;
		endcase
		if (got.kind !== e.kind) begin $error("result_kind exp %0d got %0d", e.kind, got.kind); bad++; end
		if (got.cls !== e.cls) begin $error("token_class exp %0d got %0d", e.cls, got.cls); bad++; end
		if (got.len !== e.len) begin $error("token_length exp %0d got %0d", e.len, got.len); bad++; end
		if (got.text !== e.text) begin $error("token_text exp %h got %h", e.text, got.text); bad++; end
		if (got.trunc !== e.trunc) begin
			$error("text_truncated exp %0d got %0d", e.trunc, got.trunc); bad++;
		end
		if (got.err !== e.err) begin $error("error_code exp %0d got %0d", e.err, got.err); bad++; end
		if (got.last !== e.last) begin $error("last_of_run exp %0d got %0d", e.last, got.last); bad++; end
	endfunction
endclass

// ----- bench/tb_top.sv -----
// Top of the comment_strip_lexer bench: drives program text with comments,
// tokens and faults, checks every result word. Depends on csl_pkg, the
// interfaces, tb_scoreboard.sv and the RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk, arst_n;
	csl_in_if  in_ch();
	csl_out_if out_ch();
	comment_strip_lexer u_dut (.clk(clk), .arst_n(arst_n), .in(in_ch), .out(out_ch));

	lex_scoreboard sb;
	int send_idle, recv_idle, idle_cycles, accepted;
	bit hold_off, recv_done;
	byte unsigned text_q[$];
	bit eoi_q[$];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic push_str(string s);
		for (int i = 0; i < s.len(); i++) begin
			text_q = {text_q, s[i]};
			eoi_q = {eoi_q, 1'b0};
		end
	endtask

	task automatic push_end();
		text_q = {text_q, 8'($urandom_range(0, 255))};
		eoi_q = {eoi_q, 1'b1};
	endtask

	// clean sentence: keywords, idents, numbers, operators, comments, white space
	task automatic push_program(int parts);
		string pieces[] = '{"int", "double", "scanf", "printf", "if", "then", "while",
			"do", "abc9", "Zq", "x", "longidentifier12", "12", "0.5", "3.14", "0", "7",
			"==", "=", "<=", ">", "!", "!=", "&&", "||", "&", "|", "+", "-", "*", "/",
			",", ";", "{", "}", "(", ")", "/* c */", "// ln\n", "\t", "\r\n", "  "};
		for (int i = 0; i < parts; i++) begin
			push_str(pieces[$urandom_range(0, pieces.size() - 1)]);
			push_str($urandom_range(0, 2) ? " " : "\n");
		end
	endtask

	task automatic send_all();
		while (text_q.size() > 0) begin
			while ($urandom_range(0, 99) < send_idle) begin
				in_ch.valid <= 0;
				@(posedge clk);
			end
			in_ch.valid <= 1;
			in_ch.source_byte <= text_q[0];
			in_ch.end_of_input <= eoi_q[0];
			@(posedge clk iff in_ch.ready);
			sb.note_input(text_q.pop_front(), eoi_q.pop_front());
			accepted++;
		end
		in_ch.valid <= 0;
	endtask

	task automatic drain();
		while (sb.pending.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!recv_done)
			out_ch.ready <= !hold_off && ($urandom_range(0, 99) >= recv_idle);
		if (out_ch.valid && out_ch.ready) begin
			csl_pkg::res_t r;
			r.kind = out_ch.result_kind; r.cls = out_ch.token_class;
			r.len = out_ch.token_length; r.text = out_ch.token_text;
			r.trunc = out_ch.text_truncated; r.err = out_ch.error_code;
			r.last = out_ch.last_of_run;
			sb.check_result(r);
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles > 5000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		sb = new();
		in_ch.valid = 0; in_ch.source_byte = 0; in_ch.end_of_input = 0;
		out_ch.ready = 0; hold_off = 0; recv_done = 0;
		send_idle = 0; recv_idle = 0; idle_cycles = 0; accepted = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// errors are not resettable except by reset; the block is reset only once,
		// so the fault case comes last
		send_idle = 14; recv_idle = 54;
		push_str("int double scanf printf if then while do x9 ");
		push_str("== <= != && || & | + - * / , ; { } ( )\t\r\n");
		push_str("3.25 0.5 7 abcdefghijkl /* a*b **/ q // cmt\n z/");
		push_end();
		send_all();
		drain();
		send_idle = 54; recv_idle = 14;
		push_program(5);
		push_end();
		send_all();
		drain();
		send_idle = 0; recv_idle = 0;
		fork
			begin
				hold_off = 1;
				repeat (60) @(posedge clk);
				hold_off = 0;
			end
			begin
				push_program(5);
				push_end();
				send_all();
			end
		join
		drain();
		// saturating token length, then a fault that halts the block
		for (int i = 0; i < 256; i++) push_str("a");
		push_str(" 1..2");
		push_end();
		send_all();
		drain();
		$display("Covered %0d input words: %0d tokens, %0d errors, %0d end words.",
			accepted, sb.tokens, sb.errors, sb.ends);
		if (sb.bad == 0 && sb.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
